@@ rtl/amc_pkg.sv @@
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types and fixed constants for the adaptive message coalescer.
// ----------------------------------------------------------------------------
package amc_pkg;

  // Fixed field widths
  localparam int CH_FIELD_W  = 6;
  localparam int CNT_FIELD_W = 5;
  localparam int CFG_W       = 5;
  localparam int SEC_W       = 32;
  localparam int MSEC_W      = 10;

  // Ceiling register value after reset
  localparam logic [CFG_W-1:0] CEIL_RESET = 5'd16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HDR,
    ST_REC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture transaction, read channel metadata
    logic eval;      // update batch, metadata and limit
    logic load_hdr;  // place header item in output register
    logic load_rec;  // place record item in output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_hit;      // input addresses an open, existing channel
    logic poll_empty;  // poll of an empty batch
    logic do_flush;    // batch must be flushed
    logic n_zero;      // flushed batch holds no records
    logic out_free;    // output register can take an item
    logic rec_last;    // current record is the final one
  } dp_status_t;

endpackage

@@ rtl/amc_ctrl.sv @@
// ----------------------------------------------------------------------------
// amc_ctrl
// Sequencer: take a transaction, evaluate the batch, stream out a flush.
// ----------------------------------------------------------------------------
module amc_ctrl import amc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output ctl_cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // closed or unknown channels are dropped here
        if (in_tvalid && st.in_hit) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.eval = 1'b1;
        if (!st.poll_empty && st.do_flush) begin
          state_nxt = ST_HDR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (st.out_free) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = st.n_zero ? ST_IDLE : ST_REC;
        end
      end
      ST_REC: begin
        if (st.out_free) begin
          cmd.load_rec = 1'b1;
          if (st.rec_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

@@ rtl/amc_datapath.sv @@
// ----------------------------------------------------------------------------
// amc_datapath
// Channel metadata, record store, adaptive limit and output register.
// ----------------------------------------------------------------------------
module amc_datapath import amc_pkg::*; #(
  parameter int CHANNELS    = 64,
  parameter int MAX_BATCH   = 16,
  parameter int RECORD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input fields
  input  logic                   req_type,
  input  logic [CH_FIELD_W-1:0]  channel,
  input  logic                   channel_open,
  input  logic [RECORD_BITS-1:0] message,
  input  logic [SEC_W-1:0]       now_sec,
  input  logic [MSEC_W-1:0]      now_msec,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // control
  input  ctl_cmd_t               cmd,
  output dp_status_t             st,
  // result
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CH_FIELD_W-1:0]  out_channel,
  output logic                   is_header,
  output logic [CNT_FIELD_W-1:0] batch_count,
  output logic                   flush_reason,
  output logic [RECORD_BITS-1:0] record,
  output logic                   last
);

  localparam int CNT_W     = $clog2(MAX_BATCH + 1);
  localparam int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int REC_DEPTH = CHANNELS * (2 ** IDX_W);
  localparam int META_W    = CNT_W + SEC_W + MSEC_W;
  localparam int LIM_RESET = (MAX_BATCH < 16) ? MAX_BATCH : 16;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BATCH);

  // Captured transaction
  logic                   poll_r;
  logic [CH_W-1:0]        ch_r;
  logic [RECORD_BITS-1:0] msg_r;
  logic [SEC_W-1:0]       sec_r;
  logic [MSEC_W-1:0]      msec_r;

  // Metadata store: {touch_msec, touch_sec, held_count}
  logic [META_W-1:0]      meta_mem [CHANNELS];
  logic [META_W-1:0]      meta_rd_r;
  logic [CHANNELS-1:0]    valid_r;

  // Record store, one row of 2**IDX_W slots per channel
  logic [RECORD_BITS-1:0] rec_mem [REC_DEPTH];
  logic [RECORD_BITS-1:0] rec_rd_r;

  logic [CFG_W-1:0]       ceil_r;
  logic [CNT_W-1:0]       limit_r;
  logic [CNT_W-1:0]       limit_nxt;
  logic [CNT_W-1:0]       n_r;
  logic                   reason_r;
  logic [CNT_W-1:0]       idx_r;

  logic                   out_valid_r;
  logic [CH_FIELD_W-1:0]  out_ch_r;
  logic                   out_hdr_r;
  logic [CNT_FIELD_W-1:0] out_cnt_r;
  logic                   out_why_r;
  logic [RECORD_BITS-1:0] out_rec_r;
  logic                   out_last_r;

  logic [CH_W-1:0]        in_ch;
  logic                   hit_v;
  logic [CNT_W-1:0]       cnt0;
  logic [SEC_W-1:0]       sec0;
  logic [MSEC_W-1:0]      msec0;
  logic                   room;
  logic [CNT_W-1:0]       n_new;
  logic                   by_count;
  logic                   by_time;
  logic                   poll_empty;
  logic [CMP_W-1:0]       ceil_ext;
  logic [CNT_W-1:0]       eff_ceil;
  logic [CNT_W-1:0]       idx_inc;
  logic [CNT_W-1:0]       rd_idx;
  logic                   out_free;

  assign in_ch = CH_W'(channel);

  // Metadata of the addressed channel; never-touched channels read as zero
  assign hit_v = valid_r[ch_r];
  assign cnt0  = hit_v ? meta_rd_r[CNT_W-1:0] : '0;
  assign sec0  = hit_v ? meta_rd_r[CNT_W +: SEC_W] : '0;
  assign msec0 = hit_v ? meta_rd_r[CNT_W + SEC_W +: MSEC_W] : '0;

  // Batch evaluation
  assign room       = cnt0 < MAX_CNT;
  assign n_new      = (!poll_r && room) ? CNT_W'(cnt0 + 1'b1) : cnt0;
  assign poll_empty = poll_r && (cnt0 == '0);
  assign by_count   = (n_new >= limit_r) || (n_new >= MAX_CNT);
  assign by_time    = (sec0 < sec_r) || ((sec0 == sec_r) && (msec0 != msec_r));

  // Ceiling clamped to 1..MAX_BATCH
  assign ceil_ext = CMP_W'(ceil_r);
  always_comb begin
    priority if (ceil_ext == '0) begin
      eff_ceil = CNT_W'(1);
    end else if (ceil_ext > CMP_W'(MAX_BATCH)) begin
      eff_ceil = MAX_CNT;
    end else begin
      eff_ceil = CNT_W'(ceil_ext);
    end
  end

  // Adaptive limit: up on count flush, down on time flush
  always_comb begin
    limit_nxt = limit_r;
    if (cmd.eval && !poll_empty) begin
      if (by_count) begin
        if (limit_r < eff_ceil) begin
          limit_nxt = CNT_W'(limit_r + 1'b1);
        end
      end else if (by_time) begin
        if ((n_new < limit_r) && (limit_r > CNT_W'(1))) begin
          limit_nxt = CNT_W'(limit_r - 1'b1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= CEIL_RESET;
      limit_r <= CNT_W'(LIM_RESET);
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        ceil_r <= cfg_wdata;
      end
      limit_r <= limit_nxt;
      if (cmd.eval && !poll_empty) begin
        valid_r[ch_r] <= 1'b1;
      end
    end
  end

  // Transaction capture and flush bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      poll_r <= req_type;
      ch_r   <= in_ch;
      msg_r  <= message;
      sec_r  <= now_sec;
      msec_r <= now_msec;
    end
    if (cmd.eval) begin
      n_r      <= n_new;
      reason_r <= !by_count;
    end
  end

  // Metadata memory
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meta_rd_r <= meta_mem[in_ch];
    end
    if (cmd.eval && !poll_empty) begin
      meta_mem[ch_r] <= {msec_r, sec_r, (by_count || by_time) ? '0 : n_new};
    end
  end

  // Record memory
  assign idx_inc = CNT_W'(idx_r + 1'b1);
  assign rd_idx  = cmd.load_hdr ? '0 : idx_inc;

  always_ff @(posedge clk) begin
    if (cmd.eval && !poll_r && room) begin
      rec_mem[{ch_r, cnt0[IDX_W-1:0]}] <= msg_r;
    end
    if (cmd.load_hdr || cmd.load_rec) begin
      rec_rd_r <= rec_mem[{ch_r, rd_idx[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      idx_r <= '0;
    end else if (cmd.load_rec) begin
      idx_r <= idx_inc;
    end
  end

  // Output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_rec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      out_ch_r   <= CH_FIELD_W'(ch_r);
      out_hdr_r  <= 1'b1;
      out_cnt_r  <= CNT_FIELD_W'(n_r);
      out_why_r  <= reason_r;
      out_rec_r  <= '0;
      out_last_r <= (n_r == '0);
    end else if (cmd.load_rec) begin
      out_hdr_r  <= 1'b0;
      out_rec_r  <= rec_rd_r;
      out_last_r <= (idx_inc == n_r);
    end
  end

  // Status to controller
  always_comb begin
    st            = '0;
    st.in_hit     = channel_open && (32'(channel) < 32'(CHANNELS));
    st.poll_empty = poll_empty;
    st.do_flush   = by_count || by_time;
    st.n_zero     = (n_r == '0);
    st.out_free   = out_free;
    st.rec_last   = (idx_inc == n_r);
  end

  assign out_valid    = out_valid_r;
  assign out_channel  = out_ch_r;
  assign is_header    = out_hdr_r;
  assign batch_count  = out_cnt_r;
  assign flush_reason = out_why_r;
  assign record       = out_rec_r;
  assign last         = out_last_r;

endmodule

@@ rtl/adaptive_message_coalescer.sv @@
// A flush header enters the output register in ST_HDR once that register is free,
// after the transaction passed ST_IDLE and ST_LOOKUP. No new transaction is taken
// until the flush ends; records leave the record memory port one per cycle while
// out_tready is high. Reset (rst_n, synchronous, active low) clears all batches
// and touch times at once via per-channel valid bits, sets limit and ceiling to 16.
// ----------------------------------------------------------------------------
// adaptive_message_coalescer
// Per-channel message batching with a count limit that adapts to traffic.
// ----------------------------------------------------------------------------
module adaptive_message_coalescer import amc_pkg::*; #(
  parameter int CHANNELS    = 64,
  parameter int MAX_BATCH   = 16,
  parameter int RECORD_BITS = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // channel, channel_open, message, now_sec, now_msec, zero pad
  input  logic [((RECORD_BITS + 49 + 7) / 8) * 8 - 1:0] in_tdata,
  // req_type
  input  logic                                    in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // out_channel, batch_count, flush_reason, record, zero pad
  output logic [((RECORD_BITS + 12 + 7) / 8) * 8 - 1:0] out_tdata,
  // is_header
  output logic                                    out_tuser,
  output logic                                    out_tlast,
  // configuration: limit_ceiling
  input  logic                                    cfg_we,
  input  logic [CFG_W-1:0]                        cfg_wdata
);

  localparam int IN_BITS  = CH_FIELD_W + 1 + RECORD_BITS + SEC_W + MSEC_W;
  localparam int OUT_TW   = ((RECORD_BITS + 12 + 7) / 8) * 8;
  localparam int MSG_LO   = CH_FIELD_W + 1;
  localparam int SEC_LO   = MSG_LO + RECORD_BITS;
  localparam int MSEC_LO  = SEC_LO + SEC_W;

  ctl_cmd_t               cmd;
  dp_status_t             st;
  logic [CH_FIELD_W-1:0]  o_channel;
  logic [CNT_FIELD_W-1:0] o_count;
  logic                   o_reason;
  logic [RECORD_BITS-1:0] o_record;
  logic [IN_BITS-1:0]     in_bits;

  assign in_bits = in_tdata[IN_BITS-1:0];

  amc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  amc_datapath #(
    .CHANNELS    (CHANNELS),
    .MAX_BATCH   (MAX_BATCH),
    .RECORD_BITS (RECORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_type     (in_tuser),
    .channel      (in_bits[CH_FIELD_W-1:0]),
    .channel_open (in_bits[CH_FIELD_W]),
    .message      (in_bits[MSG_LO +: RECORD_BITS]),
    .now_sec      (in_bits[SEC_LO +: SEC_W]),
    .now_msec     (in_bits[MSEC_LO +: MSEC_W]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_channel  (o_channel),
    .is_header    (out_tuser),
    .batch_count  (o_count),
    .flush_reason (o_reason),
    .record       (o_record),
    .last         (out_tlast)
  );

  // Pack result fields, lowest first
  assign out_tdata = OUT_TW'({o_record, o_reason, o_count, o_channel});

endmodule
